// ----- hw/rtl/heel_strike_detector_top_defines.svh -----
// assertion macros shared by the heel strike detector
`ifndef HEEL_STRIKE_DETECTOR_TOP_DEFINES_SVH
`define HEEL_STRIKE_DETECTOR_TOP_DEFINES_SVH

// same-cycle implication, checked on clk while out of reset
`define HSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define HSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/hsd_pkg.sv -----
`default_nettype none

package hsd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X_BASELINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z_BASELINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_Y_BASELINE  = 2'd2;

    localparam logic signed [SAMPLE_W-1:0] ACCEL_X_BASELINE_RESET = -16'sd3800;
    localparam logic [COUNT_W-1:0]         COUNT_MAX = '1;

    // one held minimum of a channel
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
    } hsd_min_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsd_min_track.sv -----
`default_nettype none

module hsd_min_track (
    input  wire logic                                enable,
    input  wire logic signed [hsd_pkg::SAMPLE_W-1:0] cur,
    input  wire logic signed [hsd_pkg::SAMPLE_W-1:0] prev,
    input  wire logic signed [hsd_pkg::SAMPLE_W-1:0] base,
    input  wire hsd_pkg::hsd_min_t                   held,
    output hsd_pkg::hsd_min_t                        updated,
    output logic                                     recorded
);
    import hsd_pkg::*;

    logic rise_below;
    logic deeper;

    // previous sample is a local minimum below baseline
    assign rise_below = (cur > prev) && (cur < base);
    assign deeper     = !held.valid || (prev < $signed(held.value));
    assign recorded   = enable && rise_below && deeper;

    always_comb
    begin
        updated = held;
        if (recorded)
        begin
            updated.valid = 1'b1;
            updated.value = prev;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/heel_strike_detector_top.sv -----
// channel     | direction | handshake               | payload
// input       | in        | in_valid / in_ready     | accel_x, accel_z, gyro_y, sample_time
// result      | out       | out_valid / out_ready   | strike, strike_time, strike_total
// config      | in        | cfg_write (no wait)     | cfg_index, cfg_data
//
// one transaction per cycle sustained unless out_ready stalls the result register
// the input register feeds one pass of compare logic that updates the tracking
// state and loads the result register in the same edge
// the input side keeps accepting while a result waits, until both registers are full
// async active-low reset: baselines to defaults, minima empty, detection armed
`default_nettype none

module heel_strike_detector_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input samples
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [hsd_pkg::SAMPLE_W-1:0]  accel_x,
    input  wire logic signed [hsd_pkg::SAMPLE_W-1:0]  accel_z,
    input  wire logic signed [hsd_pkg::SAMPLE_W-1:0]  gyro_y,
    input  wire logic        [hsd_pkg::TIME_W-1:0]    sample_time,
    // results
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic                                      strike,
    output logic             [hsd_pkg::TIME_W-1:0]    strike_time,
    output logic             [hsd_pkg::COUNT_W-1:0]   strike_total,
    // configuration writes
    input  wire logic                                 cfg_write,
    input  wire logic        [hsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [hsd_pkg::SAMPLE_W-1:0]  cfg_data
);
    import hsd_pkg::*;

    // baselines
    logic signed [SAMPLE_W-1:0] ax_base_reg;
    logic signed [SAMPLE_W-1:0] az_base_reg;
    logic signed [SAMPLE_W-1:0] gy_base_reg;

    // input register
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] ax_in_reg;
    logic signed [SAMPLE_W-1:0] az_in_reg;
    logic signed [SAMPLE_W-1:0] gy_in_reg;
    logic        [TIME_W-1:0]   time_in_reg;

    // tracking state
    logic                       have_prev_reg;
    logic signed [SAMPLE_W-1:0] prev_ax_reg;
    logic signed [SAMPLE_W-1:0] prev_az_reg;
    logic signed [SAMPLE_W-1:0] prev_gy_reg;
    hsd_min_t                   min_ax_reg;
    hsd_min_t                   min_az_reg;
    hsd_min_t                   min_gy_reg;
    logic                       armed_reg;
    logic        [COUNT_W-1:0]  count_reg;

    // result register
    logic                       out_valid_reg;
    logic                       strike_reg;
    logic        [TIME_W-1:0]   strike_time_reg;
    logic        [COUNT_W-1:0]  strike_total_reg;

    // next values
    hsd_min_t                   min_ax_next;
    hsd_min_t                   min_az_next;
    hsd_min_t                   min_gy_next;
    hsd_min_t                   min_ax_trk;
    hsd_min_t                   min_az_trk;
    hsd_min_t                   min_gy_trk;
    logic                       armed_next;
    logic        [COUNT_W-1:0]  count_next;
    logic                       gy_recorded;
    logic                       ax_recorded;
    logic                       az_recorded;
    logic                       armed_now;
    logic                       hit;
    logic                       advance;
    logic                       accept;

    // the transaction in the input register moves on when the result slot frees up
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // per-channel minimum tracking; the first sample only primes the previous values
    hsd_min_track u_trk_gy (
        .enable   (have_prev_reg),
        .cur      (gy_in_reg),
        .prev     (prev_gy_reg),
        .base     (gy_base_reg),
        .held     (min_gy_reg),
        .updated  (min_gy_trk),
        .recorded (gy_recorded)
    );

    hsd_min_track u_trk_az (
        .enable   (have_prev_reg),
        .cur      (az_in_reg),
        .prev     (prev_az_reg),
        .base     (az_base_reg),
        .held     (min_az_reg),
        .updated  (min_az_trk),
        .recorded (az_recorded)
    );

    hsd_min_track u_trk_ax (
        .enable   (have_prev_reg),
        .cur      (ax_in_reg),
        .prev     (prev_ax_reg),
        .base     (ax_base_reg),
        .held     (min_ax_reg),
        .updated  (min_ax_trk),
        .recorded (ax_recorded)
    );

    // a new gyro minimum re-arms detection before the strike check
    assign armed_now = armed_reg || gy_recorded;
    assign hit = have_prev_reg && armed_now
                 && min_gy_trk.valid && min_az_trk.valid && min_ax_trk.valid;

    always_comb
    begin
        min_ax_next = min_ax_trk;
        min_az_next = min_az_trk;
        min_gy_next = min_gy_trk;
        armed_next  = armed_now;
        count_next  = count_reg;
        if (hit)
        begin
            // strike: drop all minima and disarm until the next gyro minimum
            min_ax_next = '0;
            min_az_next = '0;
            min_gy_next = '0;
            armed_next  = 1'b0;
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // control and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_base_reg   <= ACCEL_X_BASELINE_RESET;
            az_base_reg   <= '0;
            gy_base_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_ax_reg   <= '0;
            prev_az_reg   <= '0;
            prev_gy_reg   <= '0;
            min_ax_reg    <= '0;
            min_az_reg    <= '0;
            min_gy_reg    <= '0;
            armed_reg     <= 1'b1;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_ACCEL_X_BASELINE: ax_base_reg <= $signed(cfg_data);
                    REG_ACCEL_Z_BASELINE: az_base_reg <= $signed(cfg_data);
                    REG_GYRO_Y_BASELINE:  gy_base_reg <= $signed(cfg_data);
                    default:              ;
                endcase
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                have_prev_reg <= 1'b1;
                prev_ax_reg   <= ax_in_reg;
                prev_az_reg   <= az_in_reg;
                prev_gy_reg   <= gy_in_reg;
                min_ax_reg    <= min_ax_next;
                min_az_reg    <= min_az_next;
                min_gy_reg    <= min_gy_next;
                armed_reg     <= armed_next;
                count_reg     <= count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ax_in_reg   <= accel_x;
            az_in_reg   <= accel_z;
            gy_in_reg   <= gyro_y;
            time_in_reg <= sample_time;
        end
        if (advance)
        begin
            strike_reg       <= hit;
            strike_time_reg  <= hit ? time_in_reg : '0;
            strike_total_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign strike       = strike_reg;
    assign strike_time  = strike_time_reg;
    assign strike_total = strike_total_reg;

    `include "heel_strike_detector_top_defines.svh"

    // a strike leaves no minimum held and detection disarmed
    `HSD_ASSERT_NEXT(a_strike_clears, advance && hit, !min_ax_reg.valid && !min_az_reg.valid && !min_gy_reg.valid && !armed_reg, "minima not cleared after strike")
    // counter steps by one on a strike below saturation
    `HSD_ASSERT_NEXT(a_count_step, advance && hit && (count_reg != COUNT_MAX), count_reg == $past(count_reg) + COUNT_W'(1), "strike counter did not step")
    // an empty result slot never blocks the input side
    `HSD_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, in_ready, "input stalled with result slot empty")
    // a reported strike has been counted
    `HSD_ASSERT_NOW(a_strike_counted, out_valid_reg && strike_reg, strike_total_reg != '0, "strike reported with zero total")

endmodule

`default_nettype wire

// ----- test/heel_strike_detector_top_tb.sv -----
`timescale 1ns / 100ps

module heel_strike_detector_top_tb;

    import hsd_pkg::*;

    // the one index the port decodes to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] FULL_LOW  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] FULL_HIGH = 16'sh7FFF;

    localparam int RANDOM_PER_PHASE = 125;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 5000;

    // one imu sample as it crosses the input channel
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic        [TIME_W-1:0]   sample_time;
    } sample_t;

    // one result transaction
    typedef struct packed {
        logic                strike;
        logic [TIME_W-1:0]   strike_time;
        logic [COUNT_W-1:0]  strike_total;
    } strike_t;

    // directed row: sample plus, where obvious, the result typed in by hand
    typedef struct packed {
        sample_t s;
        logic    typed;
        strike_t want;
    } stim_row_t;

    localparam strike_t BY_PREDICTOR = '0;

    // runs under the reset baselines: accel x -3800, accel z 0, gyro y 0
    localparam stim_row_t STIM_PLAN [16] = '{
        // first sample only primes the previous-sample registers
        '{'{FULL_HIGH, FULL_HIGH, FULL_HIGH, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 32'd0, 16'd0}},
        // everything falls: no rise anywhere
        '{'{FULL_LOW, FULL_LOW, FULL_LOW, 32'd0}, 1'b1, '{1'b0, 32'd0, 16'd0}},
        // all three rise while deep below baseline: strike at once
        '{'{-16'sd32767, -16'sd32767, -16'sd32767, 32'd1}, 1'b1, '{1'b1, 32'd1, 16'd1}},
        // same sample again is no rise
        '{'{-16'sd32767, -16'sd32767, -16'sd32767, 32'd2}, 1'b1, '{1'b0, 32'd0, 16'd1}},
        // rise that lands exactly on each baseline is not below it
        '{'{-16'sd3800, 16'sd0, 16'sd0, 32'd3}, 1'b1, '{1'b0, 32'd0, 16'd1}},
        '{'{-16'sd4000, -16'sd10, -16'sd10, 32'd4}, 1'b1, '{1'b0, 32'd0, 16'd1}},
        // accel x minimum alone
        '{'{-16'sd3900, -16'sd10, -16'sd10, 32'd5}, 1'b0, BY_PREDICTOR},
        '{'{-16'sd5000, -16'sd20, -16'sd20, 32'd6}, 1'b0, BY_PREDICTOR},
        // deeper accel x minimum replaces, accel z minimum joins
        '{'{-16'sd4500, -16'sd5, -16'sd20, 32'd7}, 1'b0, BY_PREDICTOR},
        '{'{-16'sd5000, -16'sd30, -16'sd40, 32'd8}, 1'b0, BY_PREDICTOR},
        // equal accel x minimum kept, gyro minimum arms: strike
        '{'{-16'sd4000, -16'sd20, -16'sd30, 32'd9}, 1'b0, BY_PREDICTOR},
        '{'{-16'sd1, -16'sd1, -16'sd1, 32'h8000_0000}, 1'b0, BY_PREDICTOR},
        '{'{16'sd0, 16'sd0, 16'sd0, 32'h7FFF_FFFF}, 1'b0, BY_PREDICTOR},
        '{'{FULL_LOW, FULL_LOW, FULL_LOW, 32'h5555_5555}, 1'b0, BY_PREDICTOR},
        // accel x completes a set held across several samples
        '{'{-16'sd3801, -16'sd1, -16'sd1, 32'hAAAA_AAAA}, 1'b0, BY_PREDICTOR},
        '{'{FULL_HIGH, FULL_LOW, 16'sd0, 32'h0000_0000}, 1'b0, BY_PREDICTOR}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic        [TIME_W-1:0]   sample_time;

    logic                       out_valid;
    logic                       out_ready;
    logic                       strike;
    logic        [TIME_W-1:0]   strike_time;
    logic        [COUNT_W-1:0]  strike_total;

    logic                       cfg_write;
    logic        [CFG_IDX_W-1:0] cfg_index;
    logic        [SAMPLE_W-1:0] cfg_data;

    // predictor copy of the baselines and the tracking state
    logic signed [SAMPLE_W-1:0] base_ax;
    logic signed [SAMPLE_W-1:0] base_az;
    logic signed [SAMPLE_W-1:0] base_gy;
    logic                       have_prev;
    logic signed [SAMPLE_W-1:0] prev_ax;
    logic signed [SAMPLE_W-1:0] prev_az;
    logic signed [SAMPLE_W-1:0] prev_gy;
    hsd_min_t                   low_ax;
    hsd_min_t                   low_az;
    hsd_min_t                   low_gy;
    logic                       armed;
    logic        [COUNT_W-1:0]  strike_count;

    // results owed by the block, oldest first
    strike_t pending_strikes[$];

    // random walk levels per channel and the running timestamp
    int          walk_ax;
    int          walk_az;
    int          walk_gy;
    int unsigned stamp_clock;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int quiet_cycles;

    heel_strike_detector_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .accel_x      (accel_x),
        .accel_z      (accel_z),
        .gyro_y       (gyro_y),
        .sample_time  (sample_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .strike       (strike),
        .strike_time  (strike_time),
        .strike_total (strike_total),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // a local minimum is the previous sample, when the channel now rises
    // but is still below its baseline; it only replaces a hold when strictly deeper
    function automatic hsd_min_t track_low(hsd_min_t held,
                                           logic signed [SAMPLE_W-1:0] cur,
                                           logic signed [SAMPLE_W-1:0] prev,
                                           logic signed [SAMPLE_W-1:0] base);
        hsd_min_t upd;
        upd = held;
        if (cur > prev && cur < base && (!held.valid || prev < $signed(held.value)))
        begin
            upd.valid = 1'b1;
            upd.value = prev;
        end
        return upd;
    endfunction

    // expected result of one accepted sample; advances the predictor state
    function automatic strike_t detect_heel_strike(sample_t s);
        strike_t  r;
        hsd_min_t gy_next;
        r = '0;
        if (have_prev)
        begin
            gy_next = track_low(low_gy, s.gyro_y, prev_gy, base_gy);
            // a fresh gyro minimum re-arms detection
            if (gy_next != low_gy)
                armed = 1'b1;
            low_gy = gy_next;
            low_az = track_low(low_az, s.accel_z, prev_az, base_az);
            low_ax = track_low(low_ax, s.accel_x, prev_ax, base_ax);
            if (low_gy.valid && low_az.valid && low_ax.valid && armed)
            begin
                r.strike      = 1'b1;
                r.strike_time = s.sample_time;
                // counter saturates, strikes still reported
                if (strike_count != COUNT_MAX)
                    strike_count = strike_count + 1'b1;
                armed  = 1'b0;
                low_gy = '0;
                low_az = '0;
                low_ax = '0;
            end
        end
        have_prev = 1'b1;
        prev_ax   = s.accel_x;
        prev_az   = s.accel_z;
        prev_gy   = s.gyro_y;
        r.strike_total = strike_count;
        return r;
    endfunction

    // next level of a channel: mostly a walk that swings across the baseline
    // so dips form, with repeats, baseline hits and full-range jumps mixed in
    function automatic int wander(int last, int base);
        int roll;
        int v;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            v = int'($urandom_range(0, 65535)) - 32768;
        else if (roll < 14)
            v = last;
        else if (roll < 18)
            v = base;
        else
            v = last + int'($urandom_range(0, 600)) - 300 + ((last >= base - 200) ? -120 : 120);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    function automatic sample_t draw_sample();
        sample_t s;
        walk_ax = wander(walk_ax, int'(base_ax));
        walk_az = wander(walk_az, int'(base_az));
        walk_gy = wander(walk_gy, int'(base_gy));
        // mostly steady time steps, now and then a jump anywhere
        if ($urandom_range(0, 99) < 15)
            stamp_clock = $urandom();
        else
            stamp_clock = stamp_clock + $urandom_range(1, 20);
        s.accel_x     = walk_ax[SAMPLE_W-1:0];
        s.accel_z     = walk_az[SAMPLE_W-1:0];
        s.gyro_y      = walk_gy[SAMPLE_W-1:0];
        s.sample_time = stamp_clock;
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction;
    // valid stays high into the next call unless the sender idles
    task automatic offer_sample(sample_t s, logic typed, strike_t want);
        strike_t calc;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        accel_x     = s.accel_x;
        accel_z     = s.accel_z;
        gyro_y      = s.gyro_y;
        sample_time = s.sample_time;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // predictor runs on every sample to keep its state in step
        calc = detect_heel_strike(s);
        pending_strikes.push_back(typed ? want : calc);
        @(negedge clk);
    endtask

    // wait until every owed result is out and the pipeline is empty
    task automatic settle();
        in_valid = 1'b0;
        while (pending_strikes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_ACCEL_X_BASELINE: base_ax = data;
            REG_ACCEL_Z_BASELINE: base_az = data;
            REG_GYRO_Y_BASELINE:  base_gy = data;
            default: ;
        endcase
    endtask

    task automatic load_baselines(logic [SAMPLE_W-1:0] ax, logic [SAMPLE_W-1:0] az,
                                  logic [SAMPLE_W-1:0] gy);
        write_reg(REG_ACCEL_X_BASELINE, ax);
        write_reg(REG_ACCEL_Z_BASELINE, az);
        write_reg(REG_GYRO_Y_BASELINE, gy);
    endtask

    // receiver: ready decided fresh at every falling edge
    always @(negedge clk)
        out_ready = ($urandom_range(0, 99) >= recv_idle_pct);

    // result checking and watchdog, all on pre-edge values
    always @(posedge clk)
    begin : result_check
        strike_t want;
        strike_t got;
        logic    moved;
        if (rst_n)
        begin
            moved = in_valid && in_ready;
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                got   = '{strike, strike_time, strike_total};
                if (pending_strikes.size() == 0)
                begin
                    $error("result transaction with nothing expected: %p", got);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_strikes[0];
                    pending_strikes.delete(0);
                    if (got.strike !== want.strike)
                    begin
                        $error("strike: expected %0d, actual %0d", want.strike, got.strike);
                        mismatch_count++;
                    end
                    if (got.strike_time !== want.strike_time)
                    begin
                        $error("strike_time: expected %0d, actual %0d",
                               want.strike_time, got.strike_time);
                        mismatch_count++;
                    end
                    if (got.strike_total !== want.strike_total)
                    begin
                        $error("strike_total: expected %0d, actual %0d",
                               want.strike_total, got.strike_total);
                        mismatch_count++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        accel_x        = '0;
        accel_z        = '0;
        gyro_y         = '0;
        sample_time    = '0;
        out_ready      = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 17;
        recv_idle_pct  = 86;

        // predictor reset state mirrors the block's
        base_ax      = ACCEL_X_BASELINE_RESET;
        base_az      = '0;
        base_gy      = '0;
        have_prev    = 1'b0;
        prev_ax      = '0;
        prev_az      = '0;
        prev_gy      = '0;
        low_ax       = '0;
        low_az       = '0;
        low_gy       = '0;
        armed        = 1'b1;
        strike_count = '0;
        walk_ax      = -4000;
        walk_az      = -200;
        walk_gy      = -200;
        stamp_clock  = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // a write to the unused index must leave the reset baselines alone
        write_reg(REG_SPARE, 16'h7FFF);

        for (int i = 0; i < $size(STIM_PLAN); i++)
            offer_sample(STIM_PLAN[i].s, STIM_PLAN[i].typed, STIM_PLAN[i].want);
        settle();

        // random phases: two baseline settings per idling mode
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 86;
                end
                1:
                begin
                    send_idle_pct = 86;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (ph)
                0: load_baselines(16'hF128, 16'h0000, 16'h0000);
                1: load_baselines(FULL_HIGH, FULL_HIGH, FULL_HIGH);
                // nothing can sit below the floor: no minimum ever forms
                2: load_baselines(FULL_LOW, FULL_LOW, FULL_LOW);
                4: load_baselines(16'h0000, FULL_LOW, FULL_HIGH);
                default: load_baselines(16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)),
                                        16'($urandom_range(0, 65535)));
            endcase
            walk_ax = int'(base_ax) - 300;
            walk_az = int'(base_az) - 300;
            walk_gy = int'(base_gy) - 300;
            repeat (RANDOM_PER_PHASE)
                offer_sample(draw_sample(), 1'b0, BY_PREDICTOR);
            settle();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
